[hw/rtl/assert_macros.svh]
// Assertion helpers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMP(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define ASSERT_NXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst, a, c, msg)
`define ASSERT_NXT(lbl, clk, rst, a, c, msg)
`endif
`endif

[hw/rtl/rbst_pkg.sv]
package rbst_pkg;
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BOX_MIN_X = 3'd0,
      REG_BOX_MIN_Y = 3'd1,
      REG_BOX_MIN_Z = 3'd2,
      REG_BOX_MAX_X = 3'd3,
      REG_BOX_MAX_Y = 3'd4,
      REG_BOX_MAX_Z = 3'd5
   } csr_index_type;
   localparam int NUM_AXES = 3;
endpackage

[hw/rtl/rbst_div_pipe.sv]
// Pipelined signed fixed-point divide: (diff << FRAC_BITS) / den, truncated
// toward zero and saturated. One numerator bit per stage.
module rbst_div_pipe import rbst_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [COORD_BITS:0]   diff,
   input  logic signed [COORD_BITS-1:0] den,
   output logic signed [COORD_BITS-1:0] quot
);
   localparam int NUM_W = COORD_BITS + 1 + FRAC_BITS;
   localparam int Q_W   = COORD_BITS - 1;

   logic [NUM_W-1:0]      num_ff [0:NUM_W];
   logic [COORD_BITS-1:0] dv_ff  [0:NUM_W];
   logic [COORD_BITS-1:0] rem_ff [0:NUM_W];
   logic [Q_W-1:0]        q_ff   [0:NUM_W];
   logic                  ovf_ff [0:NUM_W];
   logic                  neg_ff [0:NUM_W];

   logic [COORD_BITS:0]   diff_mag;
   logic [COORD_BITS-1:0] den_mag;

   assign diff_mag = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
   assign den_mag  = den[COORD_BITS-1] ? (~den + 1'b1) : den;

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= NUM_W'(diff_mag) << FRAC_BITS;
         dv_ff[0]  <= den_mag;
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
         ovf_ff[0] <= 1'b0;
         neg_ff[0] <= diff[COORD_BITS] ^ den[COORD_BITS-1];
      end
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_step
      logic [COORD_BITS:0]   trial;
      logic [COORD_BITS:0]   sub;
      logic                  ge;
      assign trial = {rem_ff[s], num_ff[s][NUM_W-1]};
      assign ge    = trial >= {1'b0, dv_ff[s]};
      assign sub   = trial - {1'b0, dv_ff[s]};
      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[s+1] <= num_ff[s] << 1;
            dv_ff[s+1]  <= dv_ff[s];
            rem_ff[s+1] <= ge ? sub[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            q_ff[s+1]   <= {q_ff[s][Q_W-2:0], ge};
            // any bit pushed past the top means the result saturates
            ovf_ff[s+1] <= ovf_ff[s] | q_ff[s][Q_W-1];
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   // an overflowed quotient is nonzero even when its kept bits are all zero
   logic neg_res;
   assign neg_res = neg_ff[NUM_W] && ((q_ff[NUM_W] != '0) || ovf_ff[NUM_W]);

   always_comb begin
      if (neg_res) begin
         quot = ovf_ff[NUM_W] ? {1'b1, {Q_W{1'b0}}} : -$signed({1'b0, q_ff[NUM_W]});
      end else begin
         quot = ovf_ff[NUM_W] ? {1'b0, {Q_W{1'b1}}} : $signed({1'b0, q_ff[NUM_W]});
      end
   end
endmodule

[hw/rtl/ray_box_slab_test.sv]
// Channel | Dir | Ports
// req     | in  | req_valid, req_stall, origin/dir xyz, t_start, t_end
// rsp     | out | rsp_valid, rsp_stall, rsp_hit_flag
// csr     | in  | csr_we, csr_index, csr_wdata
// One ray per cycle while the result is not stalled (bit-per-stage dividers,
// six in parallel).
// Synchronous reset clears valids and sets the box empty.
// A stalled result freezes the whole pipeline; nothing is dropped.
`include "assert_macros.svh"
module ray_box_slab_test import rbst_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_origin_x,
   input  logic signed [COORD_BITS-1:0] req_origin_y,
   input  logic signed [COORD_BITS-1:0] req_origin_z,
   input  logic signed [COORD_BITS-1:0] req_dir_x,
   input  logic signed [COORD_BITS-1:0] req_dir_y,
   input  logic signed [COORD_BITS-1:0] req_dir_z,
   input  logic signed [COORD_BITS-1:0] req_t_start,
   input  logic signed [COORD_BITS-1:0] req_t_end,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit_flag,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [COORD_BITS-1:0]        csr_wdata
);
   localparam int NUM_W = COORD_BITS + 1 + FRAC_BITS;
   localparam logic signed [COORD_BITS-1:0] T_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] T_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // box registers
   logic signed [COORD_BITS-1:0] bmin_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] bmax_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            bmin_ff[a] <= T_MAX;
            bmax_ff[a] <= T_MIN;
         end
      end else if (csr_we) begin
         case (csr_index)
            REG_BOX_MIN_X: bmin_ff[0] <= csr_wdata;
            REG_BOX_MIN_Y: bmin_ff[1] <= csr_wdata;
            REG_BOX_MIN_Z: bmin_ff[2] <= csr_wdata;
            REG_BOX_MAX_X: bmax_ff[0] <= csr_wdata;
            REG_BOX_MAX_Y: bmax_ff[1] <= csr_wdata;
            REG_BOX_MAX_Z: bmax_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input stage
   logic                         va_ff;
   logic signed [COORD_BITS-1:0] org_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] dir_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] lo_a_ff, hi_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         org_ff[0] <= req_origin_x;
         org_ff[1] <= req_origin_y;
         org_ff[2] <= req_origin_z;
         dir_ff[0] <= req_dir_x;
         dir_ff[1] <= req_dir_y;
         dir_ff[2] <= req_dir_z;
         lo_a_ff   <= req_t_start;
         hi_a_ff   <= req_t_end;
      end
   end

   // zero-direction axes: pass only with origin strictly inside the slab
   logic [NUM_AXES-1:0] dz_a, dneg_a, axis_ok_a;
   logic signed [COORD_BITS-1:0] q_min [NUM_AXES];
   logic signed [COORD_BITS-1:0] q_max [NUM_AXES];

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [COORD_BITS:0] dmin, dmax;
      assign dz_a[a]      = dir_ff[a] == '0;
      assign dneg_a[a]    = dir_ff[a][COORD_BITS-1];
      assign axis_ok_a[a] = !dz_a[a] ||
                            ((bmin_ff[a] < org_ff[a]) && (org_ff[a] < bmax_ff[a]));
      assign dmin = {bmin_ff[a][COORD_BITS-1], bmin_ff[a]}
                  - {org_ff[a][COORD_BITS-1], org_ff[a]};
      assign dmax = {bmax_ff[a][COORD_BITS-1], bmax_ff[a]}
                  - {org_ff[a][COORD_BITS-1], org_ff[a]};
      rbst_div_pipe #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_min (
         .clock(clock), .en(en), .diff(dmin), .den(dir_ff[a]), .quot(q_min[a]));
      rbst_div_pipe #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_max (
         .clock(clock), .en(en), .diff(dmax), .den(dir_ff[a]), .quot(q_max[a]));
   end

   // sideband alongside the divider stages
   logic                         vd_ff   [0:NUM_W];
   logic signed [COORD_BITS-1:0] lod_ff  [0:NUM_W];
   logic signed [COORD_BITS-1:0] hid_ff  [0:NUM_W];
   logic [NUM_AXES-1:0]          dzd_ff  [0:NUM_W];
   logic [NUM_AXES-1:0]          dnd_ff  [0:NUM_W];
   logic                         okd_ff  [0:NUM_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NUM_W; s++) vd_ff[s] <= 1'b0;
      end else if (en) begin
         vd_ff[0] <= va_ff;
         for (int s = 0; s < NUM_W; s++) vd_ff[s+1] <= vd_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lod_ff[0] <= lo_a_ff;
         hid_ff[0] <= hi_a_ff;
         dzd_ff[0] <= dz_a;
         dnd_ff[0] <= dneg_a;
         okd_ff[0] <= &axis_ok_a;
         for (int s = 0; s < NUM_W; s++) begin
            lod_ff[s+1] <= lod_ff[s];
            hid_ff[s+1] <= hid_ff[s];
            dzd_ff[s+1] <= dzd_ff[s];
            dnd_ff[s+1] <= dnd_ff[s];
            okd_ff[s+1] <= okd_ff[s];
         end
      end
   end

   // quotient stage: swap on negative direction, neutral for zero direction
   logic                         vq_ff, vm_ff, v2_ff, rsp_valid_ff;
   logic signed [COORD_BITS-1:0] ent_q_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] ext_q_ff [NUM_AXES];
   logic signed [COORD_BITS-1:0] lo_q_ff, hi_q_ff;
   logic                         ok_q_ff, ok_m_ff, ok_2_ff;
   logic signed [COORD_BITS-1:0] e01_ff, e2l_ff, x01_ff, x2h_ff;
   logic signed [COORD_BITS-1:0] ent_ff, ext_ff;
   logic                         rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff        <= 1'b0;
         vm_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vq_ff        <= vd_ff[NUM_W];
         vm_ff        <= vq_ff;
         v2_ff        <= vm_ff;
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            if (dzd_ff[NUM_W][a]) begin
               ent_q_ff[a] <= T_MIN;
               ext_q_ff[a] <= T_MAX;
            end else if (dnd_ff[NUM_W][a]) begin
               ent_q_ff[a] <= q_max[a];
               ext_q_ff[a] <= q_min[a];
            end else begin
               ent_q_ff[a] <= q_min[a];
               ext_q_ff[a] <= q_max[a];
            end
         end
         lo_q_ff <= lod_ff[NUM_W];
         hi_q_ff <= hid_ff[NUM_W];
         ok_q_ff <= okd_ff[NUM_W];

         e01_ff  <= (ent_q_ff[0] > ent_q_ff[1]) ? ent_q_ff[0] : ent_q_ff[1];
         e2l_ff  <= (ent_q_ff[2] > lo_q_ff) ? ent_q_ff[2] : lo_q_ff;
         x01_ff  <= (ext_q_ff[0] < ext_q_ff[1]) ? ext_q_ff[0] : ext_q_ff[1];
         x2h_ff  <= (ext_q_ff[2] < hi_q_ff) ? ext_q_ff[2] : hi_q_ff;
         ok_m_ff <= ok_q_ff;

         ent_ff  <= (e01_ff > e2l_ff) ? e01_ff : e2l_ff;
         ext_ff  <= (x01_ff < x2h_ff) ? x01_ff : x2h_ff;
         ok_2_ff <= ok_m_ff;

         // narrowing is monotonic, so only the final interval matters
         rsp_hit_ff <= ok_2_ff && (ext_ff > ent_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit_flag = rsp_hit_ff;

   `ASSERT_IMP(a_no_stall_empty, clock, reset, !rsp_valid_ff, !req_stall, "stall with empty output")
   `ASSERT_NXT(a_freeze_valid, clock, reset, !en, $stable(vq_ff) && $stable(v2_ff), "pipeline moved while stalled")
   `ASSERT_IMP(a_reset_box, clock, 1'b0, $past(reset) && !$past(csr_we), bmin_ff[0] == T_MAX && bmax_ff[0] == T_MIN, "box not empty after reset")
endmodule

[sim/ray_box_slab_test_tb.sv]
module ray_box_slab_test_tb;
   import rbst_pkg::*;

   localparam int W          = 32;
   localparam int FB         = 16;
   localparam int DRAIN_CYC  = W + FB + 12;
   localparam int CYC_LIMIT  = 400000;
   localparam logic signed [W-1:0] ONE  = 32'sh0001_0000;
   localparam logic signed [W-1:0] SMAX = 32'sh7fff_ffff;
   localparam logic signed [W-1:0] SMIN = 32'sh8000_0000;
   localparam logic [CSR_IDX_W-1:0] SPARE_IDX_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] SPARE_IDX_B = 3'd7;
   localparam int HIT_PREDICT = -1;

   typedef struct {
      logic signed [W-1:0] org [3];
      logic signed [W-1:0] dir [3];
      logic signed [W-1:0] t0;
      logic signed [W-1:0] t1;
   } ray_type;

   typedef struct {
      ray_type ray;
      int      box_sel;
      int      hit;
   } ray_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [W-1:0] req_org [3];
   logic signed [W-1:0] req_dir [3];
   logic signed [W-1:0] req_t_start = '0;
   logic signed [W-1:0] req_t_end = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit_flag;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [W-1:0] csr_wdata = '0;

   logic signed [W-1:0] box_lo [3];
   logic signed [W-1:0] box_hi [3];
   bit hit_expect_q [$];
   int errors = 0;
   int cyc = 0;
   int burst_left = 0;

   csr_index_type lo_reg [3] = '{REG_BOX_MIN_X, REG_BOX_MIN_Y, REG_BOX_MIN_Z};
   csr_index_type hi_reg [3] = '{REG_BOX_MAX_X, REG_BOX_MAX_Y, REG_BOX_MAX_Z};

   initial begin
      foreach (req_org[a]) begin
         req_org[a] = '0;
         req_dir[a] = '0;
      end
   end

   ray_box_slab_test dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_origin_x(req_org[0]), .req_origin_y(req_org[1]), .req_origin_z(req_org[2]),
      .req_dir_x(req_dir[0]), .req_dir_y(req_dir[1]), .req_dir_z(req_dir[2]),
      .req_t_start(req_t_start), .req_t_end(req_t_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit_flag(rsp_hit_flag),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (cyc > CYC_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // (diff << FB) / dir toward zero, saturated to the coordinate range
   function automatic longint slab_quot(longint diff, longint d);
      longint q;
      longint half;
      half = longint'(1) <<< (W - 1);
      q = (mag(diff) <<< FB) / mag(d);
      if (((diff < 0) != (d < 0)) && q != 0)
         return (q >= half) ? -half : -q;
      return (q > half - 1) ? half - 1 : q;
   endfunction

   function automatic bit predict_hit(ray_type r);
      longint lo, hi, mn, mx, o, d, e0, e1, tmp;
      lo = r.t0;
      hi = r.t1;
      for (int a = 0; a < 3; a++) begin
         mn = box_lo[a];
         mx = box_hi[a];
         o = r.org[a];
         d = r.dir[a];
         if (d == 0) begin
            if (!(mn < o && o < mx)) return 1'b0;
         end else begin
            e0 = slab_quot(mn - o, d);
            e1 = slab_quot(mx - o, d);
            if (d < 0) begin
               tmp = e0;
               e0 = e1;
               e1 = tmp;
            end
            if (e0 > lo) lo = e0;
            if (e1 < hi) hi = e1;
         end
         if (!(hi > lo)) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic signed [W-1:0] clip(longint v);
      if (v > longint'(SMAX)) return SMAX;
      if (v < longint'(SMIN)) return SMIN;
      return v[W-1:0];
   endfunction

   function automatic ray_type mk(longint ox, longint oy, longint oz, longint dx, longint dy,
                                  longint dz, longint t0, longint t1);
      ray_type r;
      r.org = '{clip(ox), clip(oy), clip(oz)};
      r.dir = '{clip(dx), clip(dy), clip(dz)};
      r.t0 = clip(t0);
      r.t1 = clip(t1);
      return r;
   endfunction

   function automatic ray_type gen_ray();
      ray_type r;
      int kind;
      longint c, span, o;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         foreach (r.org[a]) begin
            r.org[a] = $urandom;
            r.dir[a] = ($urandom_range(0, 5) == 0) ? '0 : $urandom;
         end
         r.t0 = $urandom;
         r.t1 = $urandom;
         return r;
      end
      foreach (r.org[a]) begin
         c = (longint'(box_lo[a]) + longint'(box_hi[a])) / 2;
         span = mag(longint'(box_hi[a]) - longint'(box_lo[a])) + 1;
         if ($urandom_range(0, 7) == 0) begin
            r.org[a] = clip(c + ((longint'($signed($urandom)) * span) >>> 33));
            r.dir[a] = '0;
         end else begin
            o = c + ((longint'($signed($urandom)) * span) >>> 29);
            r.org[a] = clip(o);
            r.dir[a] = clip(c - o + ((longint'($signed($urandom)) * span) >>> 32));
         end
      end
      r.t0 = clip(-2 * longint'(ONE) + $urandom_range(0, 5 * ONE / 2));
      r.t1 = clip(longint'(ONE) / 2 + $urandom_range(0, 5 * ONE / 2));
      if (kind == 9) begin
         // broken interval: equal ends, or the old end as start with a random end
         if ($urandom_range(0, 1)) begin
            r.t0 = r.t1;
            r.t1 = $urandom;
         end else begin
            r.t1 = r.t0;
         end
      end
      return r;
   endfunction

   task automatic report_err(string msg);
      $display("ERROR @%0d: %s", cyc, msg);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hit_expect_q.size() == 0) begin
            report_err("result transfer with nothing expected");
         end else begin
            if (rsp_hit_flag !== hit_expect_q[0])
               report_err($sformatf("hit_flag %b, expected %b", rsp_hit_flag, hit_expect_q[0]));
            void'(hit_expect_q.pop_front());
         end
      end
   end

   // receiver stall pattern, from one of four randomly re-picked modes
   int stall_mode = 0;
   always @(negedge clock) begin
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (cyc % 8 < 3);
      endcase
   end

   task automatic send_ray(ray_type r, int want);
      @(negedge clock);
      req_org = r.org;
      req_dir = r.dir;
      req_t_start = r.t0;
      req_t_end = r.t1;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      hit_expect_q.push_back((want == HIT_PREDICT) ? predict_hit(r) : want[0]);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (hit_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   task automatic set_box(logic signed [W-1:0] lo [3], logic signed [W-1:0] hi [3]);
      drain();
      for (int a = 0; a < 3; a++) begin
         @(negedge clock);
         csr_we = 1'b1;
         csr_index = lo_reg[a];
         csr_wdata = lo[a];
         @(negedge clock);
         csr_index = hi_reg[a];
         csr_wdata = hi[a];
      end
      // writes to unmapped indexes must not disturb the box
      @(negedge clock);
      csr_index = SPARE_IDX_A;
      csr_wdata = $urandom;
      @(negedge clock);
      csr_index = SPARE_IDX_B;
      csr_wdata = $urandom;
      @(negedge clock);
      csr_we = 1'b0;
      box_lo = lo;
      box_hi = hi;
   endtask

   ray_row_type rows [$];
   logic signed [W-1:0] blo [3];
   logic signed [W-1:0] bhi [3];
   int cur_box;

   initial begin
      longint c, h;
      foreach (box_lo[a]) begin
         box_lo[a] = SMAX;
         box_hi[a] = SMIN;
      end
      // box 0: reset (empty), 1: cube from -ONE to ONE, 2: full range
      rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 10 * ONE), 0, 0});
      rows.push_back('{mk(0, 0, 0, ONE, ONE, ONE, 0, 10 * ONE), 0, HIT_PREDICT});
      rows.push_back('{mk(-5 * ONE, 0, 0, ONE, 0, 0, 0, 10 * ONE), 1, 1});
      rows.push_back('{mk(5 * ONE, 0, 0, -ONE, 0, 0, 0, 10 * ONE), 1, 1});
      rows.push_back('{mk(-5 * ONE, 5 * ONE, 0, ONE, 0, 0, 0, 10 * ONE), 1, 0});
      rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, ONE), 1, 1});
      rows.push_back('{mk(ONE, 0, 0, 0, 0, 0, 0, ONE), 1, 0});
      rows.push_back('{mk(-5 * ONE, 0, 0, ONE, 0, 0, 10 * ONE, 0), 1, 0});
      rows.push_back('{mk(-5 * ONE, 0, 0, ONE, 0, 0, ONE, ONE), 1, 0});
      rows.push_back('{mk(-5 * ONE, 0, 0, ONE, 0, 0, 0, 3 * ONE), 1, 0});
      rows.push_back('{mk(-5 * ONE, 0, 0, ONE, 0, 0, SMIN, SMAX), 1, 1});
      rows.push_back('{mk(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMIN, SMAX), 1, HIT_PREDICT});
      rows.push_back('{mk(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN, SMAX), 1, HIT_PREDICT});
      rows.push_back('{mk(0, 0, 0, -1, -1, -1, SMIN, SMAX), 1, HIT_PREDICT});
      rows.push_back('{mk(0, 0, 0, 1, 1, 1, 0, SMAX), 1, HIT_PREDICT});
      rows.push_back('{mk(-2, ONE / 2, -ONE / 2, 3, -7, 11, -ONE, ONE), 1, HIT_PREDICT});
      rows.push_back('{mk(0, 0, 0, ONE, -ONE, ONE, SMIN, SMAX), 2, HIT_PREDICT});
      rows.push_back('{mk(SMIN, 0, 0, 0, ONE, ONE, SMIN, SMAX), 2, 0});
      rows.push_back('{mk(SMAX, SMIN, 0, -1, 1, 0, SMIN, SMAX), 2, HIT_PREDICT});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      cur_box = 0;
      foreach (rows[i]) begin
         if (rows[i].box_sel != cur_box) begin
            cur_box = rows[i].box_sel;
            foreach (blo[a]) begin
               blo[a] = (cur_box == 1) ? -ONE : SMIN;
               bhi[a] = (cur_box == 1) ? ONE : SMAX;
            end
            set_box(blo, bhi);
         end
         send_ray(rows[i].ray, rows[i].hit);
      end

      for (int ph = 0; ph < 8; ph++) begin
         foreach (blo[a]) begin
            c = longint'($signed($urandom)) >>> 6;
            h = $urandom_range(ONE / 16, 200 * ONE);
            case (ph)
               2: begin
                  blo[a] = SMIN;
                  bhi[a] = SMAX;
               end
               5: begin
                  blo[a] = $urandom;
                  bhi[a] = $urandom;
               end
               6: begin
                  // inverted box
                  blo[a] = clip(c + h);
                  bhi[a] = clip(c - h);
               end
               7: begin
                  blo[a] = SMAX;
                  bhi[a] = SMIN;
               end
               default: begin
                  blo[a] = clip(c - h);
                  bhi[a] = clip(c + h);
               end
            endcase
         end
         set_box(blo, bhi);
         for (int n = 0; n < 225; n++) begin
            if (ph == 3 && n == 100) drain();
            send_ray(gen_ray(), HIT_PREDICT);
         end
      end

      drain();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/rbst_pkg.sv
hw/rtl/rbst_div_pipe.sv
hw/rtl/ray_box_slab_test.sv
sim/ray_box_slab_test_tb.sv
